FILE: src/assert_macros.svh
// Assertion macros shared by the evidence fusion RTL.
// Depends on nothing; each user module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside of reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check on every clock edge, reset included
`define ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/dsef_pkg.sv
// Package for the evidence fusion unit: transaction types, constants, microcode.
// Used by dsef_useq and the top level; depends on nothing.
package dsef_pkg;

    localparam int MASS_W        = 16;
    localparam int HINT_W        = 8;
    localparam int FRAC_BITS_DEF = 15;
    localparam logic [MASS_W-1:0] NORM_RESET = 16'd33;

    localparam logic [HINT_W-1:0] HINT_STATIC  = 8'd1;
    localparam logic [HINT_W-1:0] HINT_DYNAMIC = 8'd2;

    // Input and result transactions
    typedef struct packed {
        logic              start_group;
        logic              occupied;
        logic [MASS_W-1:0] confidence;
        logic [MASS_W-1:0] reliability;
        logic [HINT_W-1:0] class_hint;
    } in_item_t;

    typedef struct packed {
        logic [MASS_W-1:0] mass_static_out;
        logic [MASS_W-1:0] mass_dynamic_out;
        logic [MASS_W-1:0] mass_unknown_out;
        logic [MASS_W-1:0] mass_ignorance_out;
        logic              unnormalized;
    } out_item_t;

    // Mass lanes
    localparam logic [1:0] LANE_S = 2'd0;
    localparam logic [1:0] LANE_D = 2'd1;
    localparam logic [1:0] LANE_U = 2'd2;
    localparam logic [1:0] LANE_I = 2'd3;

    // Datapath operations
    typedef enum logic [2:0] {
        UOP_NOP   = 3'd0,
        UOP_WAIT  = 3'd1,
        UOP_MUL   = 3'd2,
        UOP_WLOAD = 3'd3,
        UOP_SUM   = 3'd4,
        UOP_CHECK = 3'd5,
        UOP_DIV   = 3'd6,
        UOP_STORE = 3'd7
    } uop_t;

    // Multiplier operand selects
    typedef enum logic [2:0] {
        A_CONF = 3'd0,
        A_RS   = 3'd1,
        A_RD   = 3'd2,
        A_RU   = 3'd3,
        A_RI   = 3'd4
    } asel_t;

    typedef enum logic [2:0] {
        B_REL = 3'd0,
        B_BS  = 3'd1,
        B_BD  = 3'd2,
        B_BU  = 3'd3,
        B_BI  = 3'd4
    } bsel_t;

    // Sequencer jump conditions
    typedef enum logic [2:0] {
        J_NEXT     = 3'd0,
        J_WAIT_IN  = 3'd1,
        J_IF_RAW   = 3'd2,
        J_LOOP_DIV = 3'd3,
        J_WAIT_OUT = 3'd4,
        J_GOTO     = 3'd5
    } jmp_t;

    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] step_t;

    // Program steps
    localparam step_t S_WAIT    = 5'd0;
    localparam step_t S_MUL_W   = 5'd1;
    localparam step_t S_LOAD_W  = 5'd2;
    localparam step_t S_SS      = 5'd3;
    localparam step_t S_SI      = 5'd4;
    localparam step_t S_IS      = 5'd5;
    localparam step_t S_DD      = 5'd6;
    localparam step_t S_DI      = 5'd7;
    localparam step_t S_ID      = 5'd8;
    localparam step_t S_UU      = 5'd9;
    localparam step_t S_UI      = 5'd10;
    localparam step_t S_IU      = 5'd11;
    localparam step_t S_II      = 5'd12;
    localparam step_t S_ACC_I   = 5'd13;
    localparam step_t S_SUM     = 5'd14;
    localparam step_t S_CHECK   = 5'd15;
    localparam step_t S_DIV     = 5'd16;
    localparam step_t S_STORE   = 5'd17;
    localparam step_t UCODE_LEN = 5'd18;

    typedef struct packed {
        uop_t       op;
        asel_t      a_sel;
        bsel_t      b_sel;
        logic       acc_en;
        logic [1:0] acc_lane;
        jmp_t       jmp;
        step_t      target;
    } ucode_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic in_fire;
        logic raw;
        logic div_last;
        logic out_busy;
    } seq_stat_t;

    // Control store: the accumulate field adds the product of the previous step
    function automatic ucode_t ucode(input step_t step);
        ucode_t u;
        u = '{op: UOP_NOP, a_sel: A_CONF, b_sel: B_REL, acc_en: 1'b0,
              acc_lane: LANE_S, jmp: J_NEXT, target: S_WAIT};
        case (step)
            S_WAIT:
            begin
                u.op  = UOP_WAIT;
                u.jmp = J_WAIT_IN;
            end
            S_MUL_W:
            begin
                u.op = UOP_MUL; u.a_sel = A_CONF; u.b_sel = B_REL;
            end
            S_LOAD_W:
            begin
                u.op = UOP_WLOAD;
            end
            S_SS:
            begin
                u.op = UOP_MUL; u.a_sel = A_RS; u.b_sel = B_BS;
            end
            S_SI:
            begin
                u.op = UOP_MUL; u.a_sel = A_RS; u.b_sel = B_BI;
                u.acc_en = 1'b1; u.acc_lane = LANE_S;
            end
            S_IS:
            begin
                u.op = UOP_MUL; u.a_sel = A_RI; u.b_sel = B_BS;
                u.acc_en = 1'b1; u.acc_lane = LANE_S;
            end
            S_DD:
            begin
                u.op = UOP_MUL; u.a_sel = A_RD; u.b_sel = B_BD;
                u.acc_en = 1'b1; u.acc_lane = LANE_S;
            end
            S_DI:
            begin
                u.op = UOP_MUL; u.a_sel = A_RD; u.b_sel = B_BI;
                u.acc_en = 1'b1; u.acc_lane = LANE_D;
            end
            S_ID:
            begin
                u.op = UOP_MUL; u.a_sel = A_RI; u.b_sel = B_BD;
                u.acc_en = 1'b1; u.acc_lane = LANE_D;
            end
            S_UU:
            begin
                u.op = UOP_MUL; u.a_sel = A_RU; u.b_sel = B_BU;
                u.acc_en = 1'b1; u.acc_lane = LANE_D;
            end
            S_UI:
            begin
                u.op = UOP_MUL; u.a_sel = A_RU; u.b_sel = B_BI;
                u.acc_en = 1'b1; u.acc_lane = LANE_U;
            end
            S_IU:
            begin
                u.op = UOP_MUL; u.a_sel = A_RI; u.b_sel = B_BU;
                u.acc_en = 1'b1; u.acc_lane = LANE_U;
            end
            S_II:
            begin
                u.op = UOP_MUL; u.a_sel = A_RI; u.b_sel = B_BI;
                u.acc_en = 1'b1; u.acc_lane = LANE_U;
            end
            S_ACC_I:
            begin
                u.acc_en = 1'b1; u.acc_lane = LANE_I;
            end
            S_SUM:
            begin
                u.op = UOP_SUM;
            end
            S_CHECK:
            begin
                u.op = UOP_CHECK; u.jmp = J_IF_RAW; u.target = S_STORE;
            end
            S_DIV:
            begin
                u.op = UOP_DIV; u.jmp = J_LOOP_DIV;
            end
            S_STORE:
            begin
                u.op = UOP_STORE; u.jmp = J_WAIT_OUT; u.target = S_WAIT;
            end
            default:
            begin
                u.jmp = J_GOTO; u.target = S_WAIT;
            end
        endcase
        return u;
    endfunction

endpackage

FILE: src/dsef_useq.sv
// Microcode sequencer of the evidence fusion unit: step counter and control store.
// Depends on dsef_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dsef_useq (
    input  logic                clk,
    input  logic                rst_n,
    input  dsef_pkg::seq_stat_t stat,
    output dsef_pkg::ucode_t    ctrl
);

    dsef_pkg::step_t step_reg;
    dsef_pkg::step_t step_next;

    logic            mul_step;
    logic            store_step;
    logic            div_done;

    // Fetch the control word of the current step
    assign ctrl = dsef_pkg::ucode(step_reg);

    // Pick the next step
    always_comb
    begin
        case (ctrl.jmp)
            dsef_pkg::J_NEXT:     step_next = step_reg + 1'b1;
            dsef_pkg::J_WAIT_IN:  step_next = stat.in_fire ? step_reg + 1'b1 : step_reg;
            dsef_pkg::J_IF_RAW:   step_next = stat.raw ? ctrl.target : step_reg + 1'b1;
            dsef_pkg::J_LOOP_DIV: step_next = stat.div_last ? step_reg + 1'b1 : step_reg;
            dsef_pkg::J_WAIT_OUT: step_next = stat.out_busy ? step_reg : ctrl.target;
            dsef_pkg::J_GOTO:     step_next = ctrl.target;
            default:              step_next = dsef_pkg::S_WAIT;
        endcase
    end

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= dsef_pkg::S_WAIT;
        else
            step_reg <= step_next;
    end

    // Step kinds watched below
    assign mul_step   = (ctrl.op == dsef_pkg::UOP_MUL);
    assign store_step = (ctrl.op == dsef_pkg::UOP_STORE);
    assign div_done   = (ctrl.op == dsef_pkg::UOP_DIV) && stat.div_last;

    `ASSERT_CLK(a_step_in_program, (step_reg < dsef_pkg::UCODE_LEN), "step beyond program")
    `ASSERT_CLK(a_fire_starts_mul, stat.in_fire |=> mul_step, "no multiply after accept")
    `ASSERT_CLK(a_div_ends_store, div_done |=> store_step, "division does not end in store")

endmodule

FILE: src/dempster_shafer_evidence_fusion_unit.sv
// Top level of the evidence fusion unit: datapath, config register, output register.
// Depends on dsef_pkg, dsef_useq and assert_macros.svh.
//
//   channel  | dir | handshake                 | payload
//   ---------+-----+---------------------------+----------------------
//   input    | in  | in_valid / in_stall       | in_data  (in_item_t)
//   result   | out | out_valid / out_stall     | out_data (out_item_t)
//   config   | in  | cfg_we                    | cfg_wdata
//
// One transaction goes through the single shared multiplier (eleven products) and the
// quotient loop that retires one bit per cycle for all four masses; an item whose sum is
// at or below the threshold skips the quotient loop and stores its raw masses.
// Reset (async, active low) leaves pure ignorance as running belief and threshold 33.
// A stalled result holds the program at its store step; the next input is taken
// while a finished result still waits.
`include "assert_macros.svh"

module dempster_shafer_evidence_fusion_unit #(
    parameter int FRAC_BITS = dsef_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  dsef_pkg::in_item_t    in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output dsef_pkg::out_item_t   out_data,
    input  logic                  cfg_we,
    input  logic [dsef_pkg::MASS_W-1:0] cfg_wdata
);

    localparam int OW    = dsef_pkg::MASS_W;
    localparam int MW    = FRAC_BITS + 1;
    localparam int XW    = (MW > OW) ? MW : OW;
    localparam int AW    = MW + 2;
    localparam int SW    = MW + 4;
    localparam int CW    = (SW > OW) ? SW : OW;
    localparam int PW    = 2 * MW;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam logic [MW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    dsef_pkg::ucode_t    ctrl;
    dsef_pkg::seq_stat_t stat;

    logic              in_fire;
    logic              out_busy;
    logic              raw_now;
    logic              out_load;

    logic [MW-1:0]     conf_sat;
    logic [MW-1:0]     rel_sat;
    logic [XW-1:0]     conf_x;
    logic [XW-1:0]     rel_x;

    logic [MW-1:0]     conf_reg;
    logic [MW-1:0]     rel_reg;
    logic              occ_reg;
    logic [dsef_pkg::HINT_W-1:0] hint_reg;
    logic [MW-1:0]     w_reg;
    logic [PW-1:0]     prod_reg;
    logic [MW-1:0]     term;
    logic [MW-1:0]     mul_a;
    logic [MW-1:0]     mul_b;
    logic [MW-1:0]     bel [4];

    logic [AW-1:0]     c_reg [4];
    logic [SW-1:0]     sum_reg;
    logic [SW-1:0]     sum_next;
    logic              raw_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SW:0]       rem_reg [4];
    logic [SW:0]       rem_next [4];
    logic [MW-1:0]     q_reg [4];
    logic [MW-1:0]     q_next [4];

    logic [MW-1:0]     run_reg [4];
    logic [MW-1:0]     run_next [4];
    logic [OW-1:0]     min_norm_reg;
    dsef_pkg::out_item_t out_reg;
    dsef_pkg::out_item_t out_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    logic              run_in_range;
    logic              rem_in_range;

    // Sequencer
    dsef_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    // Handshakes
    assign in_stall = (ctrl.op != dsef_pkg::UOP_WAIT);
    assign in_fire  = in_valid && !in_stall;
    assign out_busy = out_valid_reg && out_stall;
    assign out_load = (ctrl.op == dsef_pkg::UOP_STORE) && !out_busy;

    assign raw_now = !(CW'(sum_reg) > CW'(min_norm_reg));

    assign stat.in_fire  = in_fire;
    assign stat.raw      = raw_now;
    assign stat.div_last = (cnt_reg == '0);
    assign stat.out_busy = out_busy;

    // Saturate incoming confidence and reliability at one
    assign conf_x   = XW'(in_data.confidence);
    assign rel_x    = XW'(in_data.reliability);
    assign conf_sat = (conf_x > XW'(ONE)) ? ONE : MW'(conf_x);
    assign rel_sat  = (rel_x > XW'(ONE)) ? ONE : MW'(rel_x);

    // Sensor belief from the weight
    always_comb
    begin
        bel[0] = (occ_reg && hint_reg == dsef_pkg::HINT_STATIC) ? w_reg : '0;
        bel[1] = (occ_reg && hint_reg == dsef_pkg::HINT_DYNAMIC) ? w_reg : '0;
        bel[2] = (occ_reg && hint_reg != dsef_pkg::HINT_STATIC
                  && hint_reg != dsef_pkg::HINT_DYNAMIC) ? w_reg : '0;
        bel[3] = occ_reg ? ONE - w_reg : ONE;
    end

    // Multiplier operand selection
    always_comb
    begin
        case (ctrl.a_sel)
            dsef_pkg::A_CONF: mul_a = conf_reg;
            dsef_pkg::A_RS:   mul_a = run_reg[0];
            dsef_pkg::A_RD:   mul_a = run_reg[1];
            dsef_pkg::A_RU:   mul_a = run_reg[2];
            dsef_pkg::A_RI:   mul_a = run_reg[3];
            default:          mul_a = '0;
        endcase
        case (ctrl.b_sel)
            dsef_pkg::B_REL: mul_b = rel_reg;
            dsef_pkg::B_BS:  mul_b = bel[0];
            dsef_pkg::B_BD:  mul_b = bel[1];
            dsef_pkg::B_BU:  mul_b = bel[2];
            dsef_pkg::B_BI:  mul_b = bel[3];
            default:         mul_b = '0;
        endcase
    end

    // Truncated product of the previous step
    assign term = MW'(prod_reg >> FRAC_BITS);

    assign sum_next = SW'(c_reg[0]) + SW'(c_reg[1]) + SW'(c_reg[2]) + SW'(c_reg[3]);

    // One restoring quotient bit per lane
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (rem_reg[k] >= {1'b0, sum_reg})
            begin
                rem_next[k] = {rem_reg[k][SW-1:0] - sum_reg, 1'b0};
                q_next[k]   = {q_reg[k][MW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = {rem_reg[k][SW-1:0], 1'b0};
                q_next[k]   = {q_reg[k][MW-2:0], 1'b0};
            end
        end
    end

    // New running belief: raw masses or quotients, saturated at one
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (raw_reg)
                run_next[k] = (c_reg[k] > AW'(ONE)) ? ONE : MW'(c_reg[k]);
            else
                run_next[k] = (q_reg[k] > ONE) ? ONE : q_reg[k];
        end
        out_next.mass_static_out    = OW'(run_next[0]);
        out_next.mass_dynamic_out   = OW'(run_next[1]);
        out_next.mass_unknown_out   = OW'(run_next[2]);
        out_next.mass_ignorance_out = OW'(run_next[3]);
        out_next.unnormalized       = raw_reg;
    end

    assign out_valid_next = out_load || out_busy;

    // Control state: running belief, threshold, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg[0]    <= '0;
            run_reg[1]    <= '0;
            run_reg[2]    <= '0;
            run_reg[3]    <= ONE;
            min_norm_reg  <= dsef_pkg::NORM_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                min_norm_reg <= cfg_wdata;
            if (in_fire && in_data.start_group)
            begin
                run_reg[0] <= '0;
                run_reg[1] <= '0;
                run_reg[2] <= '0;
                run_reg[3] <= ONE;
            end
            else if (out_load)
            begin
                for (int k = 0; k < 4; k++)
                    run_reg[k] <= run_next[k];
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            conf_reg <= conf_sat;
            rel_reg  <= rel_sat;
            occ_reg  <= in_data.occupied;
            hint_reg <= in_data.class_hint;
            for (int k = 0; k < 4; k++)
                c_reg[k] <= '0;
        end
        else if (ctrl.acc_en)
            c_reg[ctrl.acc_lane] <= c_reg[ctrl.acc_lane] + AW'(term);

        if (ctrl.op == dsef_pkg::UOP_MUL)
            prod_reg <= mul_a * mul_b;

        if (ctrl.op == dsef_pkg::UOP_WLOAD)
            w_reg <= term;

        if (ctrl.op == dsef_pkg::UOP_SUM)
            sum_reg <= sum_next;

        if (ctrl.op == dsef_pkg::UOP_CHECK)
        begin
            raw_reg <= raw_now;
            cnt_reg <= CNT_W'(FRAC_BITS);
            for (int k = 0; k < 4; k++)
            begin
                rem_reg[k] <= (SW+1)'(c_reg[k]);
                q_reg[k]   <= '0;
            end
        end
        else if (ctrl.op == dsef_pkg::UOP_DIV)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            for (int k = 0; k < 4; k++)
            begin
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
            end
        end

        if (out_load)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Range conditions watched below
    assign run_in_range = (run_reg[0] <= ONE) && (run_reg[1] <= ONE)
                          && (run_reg[2] <= ONE) && (run_reg[3] <= ONE);
    assign rem_in_range = (rem_reg[0] < {sum_reg, 1'b0}) && (rem_reg[1] < {sum_reg, 1'b0})
                          && (rem_reg[2] < {sum_reg, 1'b0}) && (rem_reg[3] < {sum_reg, 1'b0});

    `ASSERT_CLK(a_run_le_one, run_in_range, "running mass above one")
    `ASSERT_CLK(a_rem_bound, (ctrl.op == dsef_pkg::UOP_DIV) |-> rem_in_range, "remainder out of range")
    `ASSERT_ALL(a_reset_idle, !rst_n |=> !out_valid_reg, "result valid after reset")

endmodule
